// ----- sv/clmd_pkg.sv -----
// Package for the Content-Length message deframer.
// Holds result kinds, length width, header key lookup and the result payload type.
// No dependencies.
package clmd_pkg;

  localparam int LEN_W = 31;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  localparam logic [3:0] KEY_LEN = 4'd14;

  localparam logic [1:0] KIND_BODY    = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_NO_LEN  = 2'd2;
  localparam logic [1:0] KIND_TRUNC   = 2'd3;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } result_t;

  // Character of "Content-Length" at a key position.
  function automatic logic [7:0] key_char(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = "C";
      4'd1:    ch = "o";
      4'd2:    ch = "n";
      4'd3:    ch = "t";
      4'd4:    ch = "e";
      4'd5:    ch = "n";
      4'd6:    ch = "t";
      4'd7:    ch = "-";
      4'd8:    ch = "L";
      4'd9:    ch = "e";
      4'd10:   ch = "n";
      4'd11:   ch = "g";
      4'd12:   ch = "t";
      4'd13:   ch = "h";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- sv/clmd_in_if.sv -----
// Input channel of the deframer: valid/ready plus one stream byte or end mark.
// No dependencies.
interface clmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_stream;

  modport source (output valid, output byte_in, output end_of_stream, input ready);
  modport sink   (input valid, input byte_in, input end_of_stream, output ready);
endinterface

// ----- sv/clmd_out_if.sv -----
// Result channel of the deframer: valid/ready plus kind, data and last mark.
// No dependencies.
interface clmd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data;
  logic       last;

  modport source (output valid, output kind, output data, output last, input ready);
  modport sink   (input valid, input kind, input data, input last, output ready);
endinterface

// ----- sv/content_length_message_deframer.sv -----
// Content-Length message deframer, top level.
// Depends on clmd_pkg, clmd_in_if and clmd_out_if.
//
// Takes one stream byte per transfer and parses header lines (CR dropped, LF ends a line);
// a "Content-Length:" line sets the body length (atoi style, saturating at 2^31-1,
// negative means no length). An empty line releases the body bytes with a last mark, or
// reports an empty message or a missing length; end of stream resets the parser and
// reports a truncated body if one was open. One input transfer per cycle while input ready
// is high: each byte updates the header and counter registers, and its result (at most
// one) is registered in the output register, or in the skid entry while that is held. A
// two-entry output stage (output register plus skid) keeps input flowing during an output
// stall until the skid entry is occupied; input ready drops only while it is occupied.
module content_length_message_deframer (
  input  logic              clk,
  input  logic              rst_n,
  clmd_in_if.sink           in_ch,
  clmd_out_if.source        out_ch
);

  localparam logic [1:0] PH_WS     = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam int LW = clmd_pkg::LEN_W;

  logic          newline_seen_r, newline_seen_nxt;
  logic          length_known_r, length_known_nxt;
  logic [LW-1:0] message_length_r, message_length_nxt;
  logic          in_body_r, in_body_nxt;
  logic [LW-1:0] body_left_r, body_left_nxt;
  logic          line_has_chars_r, line_has_chars_nxt;
  logic [3:0]    key_position_r, key_position_nxt;
  logic          key_failed_r, key_failed_nxt;
  logic          past_colon_r, past_colon_nxt;
  logic [1:0]    number_phase_r, number_phase_nxt;
  logic          number_negative_r, number_negative_nxt;
  logic [LW-1:0] number_value_r, number_value_nxt;

  logic                res_valid;
  clmd_pkg::result_t   res;

  logic                out_valid_r;
  clmd_pkg::result_t   out_r;
  logic                skid_valid_r;
  clmd_pkg::result_t   skid_r;

  logic                in_xfer;
  logic                out_xfer;
  logic [7:0]          c;
  logic                is_ws, is_sign, is_digit;
  logic [LW+3:0]       acc;
  logic [LW-1:0]       acc_sat;

  assign in_ch.ready = !skid_valid_r;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = out_valid_r && out_ch.ready;
  assign c           = in_ch.byte_in;

  assign is_ws    = (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
  assign is_sign  = (c == "+") || (c == "-");
  assign is_digit = (c >= "0") && (c <= "9");

  // value * 10 + digit
  assign acc = {1'b0, number_value_r, 3'b000} + {3'b000, number_value_r, 1'b0}
             + {{(LW){1'b0}}, (c[3:0] - 4'd0)};
  assign acc_sat = (acc > {4'b0000, clmd_pkg::LEN_MAX}) ? clmd_pkg::LEN_MAX : acc[LW-1:0];

  always_comb begin
    newline_seen_nxt    = newline_seen_r;
    length_known_nxt    = length_known_r;
    message_length_nxt  = message_length_r;
    in_body_nxt         = in_body_r;
    body_left_nxt       = body_left_r;
    line_has_chars_nxt  = line_has_chars_r;
    key_position_nxt    = key_position_r;
    key_failed_nxt      = key_failed_r;
    past_colon_nxt      = past_colon_r;
    number_phase_nxt    = number_phase_r;
    number_negative_nxt = number_negative_r;
    number_value_nxt    = number_value_r;
    res_valid           = 1'b0;
    res.kind            = clmd_pkg::KIND_BODY;
    res.data            = 8'h00;
    res.last            = 1'b0;

    if (in_xfer) begin
      if (in_ch.end_of_stream) begin
        res_valid           = in_body_r;
        res.kind            = clmd_pkg::KIND_TRUNC;
        res.last            = 1'b1;
        newline_seen_nxt    = 1'b0;
        length_known_nxt    = 1'b0;
        message_length_nxt  = '0;
        in_body_nxt         = 1'b0;
        body_left_nxt       = '0;
        line_has_chars_nxt  = 1'b0;
        key_position_nxt    = '0;
        key_failed_nxt      = 1'b0;
        past_colon_nxt      = 1'b0;
        number_phase_nxt    = PH_WS;
        number_negative_nxt = 1'b0;
        number_value_nxt    = '0;
      end else if (in_body_r) begin
        res_valid = 1'b1;
        res.kind  = clmd_pkg::KIND_BODY;
        res.data  = c;
        res.last  = (body_left_r <= {{(LW-1){1'b0}}, 1'b1});
        if (res.last) begin
          body_left_nxt = '0;
          in_body_nxt   = 1'b0;
        end else begin
          body_left_nxt = body_left_r - {{(LW-1){1'b0}}, 1'b1};
        end
      end else if (c == clmd_pkg::CH_LF) begin
        if (newline_seen_r) begin
          if (!length_known_r) begin
            res_valid = 1'b1;
            res.kind  = clmd_pkg::KIND_NO_LEN;
          end else if (message_length_r == '0) begin
            res_valid = 1'b1;
            res.kind  = clmd_pkg::KIND_EMPTY;
            res.last  = 1'b1;
          end else begin
            in_body_nxt   = 1'b1;
            body_left_nxt = message_length_r;
          end
          length_known_nxt   = 1'b0;
          message_length_nxt = '0;
        end else if (line_has_chars_r && past_colon_r && !key_failed_r) begin
          if (number_negative_r && number_value_r != '0) begin
            length_known_nxt   = 1'b0;
            message_length_nxt = '0;
          end else begin
            length_known_nxt   = 1'b1;
            message_length_nxt = number_value_r;
          end
        end
        line_has_chars_nxt  = 1'b0;
        key_position_nxt    = '0;
        key_failed_nxt      = 1'b0;
        past_colon_nxt      = 1'b0;
        number_phase_nxt    = PH_WS;
        number_negative_nxt = 1'b0;
        number_value_nxt    = '0;
        newline_seen_nxt    = 1'b1;
      end else if (c != clmd_pkg::CH_CR) begin
        newline_seen_nxt   = 1'b0;
        line_has_chars_nxt = 1'b1;
        if (past_colon_r) begin
          if (!key_failed_r) begin
            if (number_phase_r == PH_WS && is_ws) begin
              number_phase_nxt = PH_WS;
            end else if (number_phase_r == PH_WS && is_sign) begin
              number_negative_nxt = (c == "-");
              number_phase_nxt    = PH_SIGN;
            end else if (number_phase_r != PH_DONE && is_digit) begin
              number_value_nxt = acc_sat;
              number_phase_nxt = PH_DIGITS;
            end else begin
              number_phase_nxt = PH_DONE;
            end
          end
        end else if (c == clmd_pkg::CH_COLON) begin
          if (key_position_r != clmd_pkg::KEY_LEN) key_failed_nxt = 1'b1;
          past_colon_nxt = 1'b1;
        end else if (!key_failed_r) begin
          if (key_position_r < clmd_pkg::KEY_LEN && c == clmd_pkg::key_char(key_position_r)) begin
            key_position_nxt = key_position_r + 4'd1;
          end else begin
            key_failed_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newline_seen_r    <= 1'b0;
      length_known_r    <= 1'b0;
      message_length_r  <= '0;
      in_body_r         <= 1'b0;
      body_left_r       <= '0;
      line_has_chars_r  <= 1'b0;
      key_position_r    <= '0;
      key_failed_r      <= 1'b0;
      past_colon_r      <= 1'b0;
      number_phase_r    <= PH_WS;
      number_negative_r <= 1'b0;
      number_value_r    <= '0;
    end else begin
      newline_seen_r    <= newline_seen_nxt;
      length_known_r    <= length_known_nxt;
      message_length_r  <= message_length_nxt;
      in_body_r         <= in_body_nxt;
      body_left_r       <= body_left_nxt;
      line_has_chars_r  <= line_has_chars_nxt;
      key_position_r    <= key_position_nxt;
      key_failed_r      <= key_failed_nxt;
      past_colon_r      <= past_colon_nxt;
      number_phase_r    <= number_phase_nxt;
      number_negative_r <= number_negative_nxt;
      number_value_r    <= number_value_nxt;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_xfer) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_xfer) begin
      out_valid_r <= res_valid;
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_xfer) out_r <= skid_r;
    end else if (!out_valid_r || out_xfer) begin
      out_r <= res;
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.kind  = out_r.kind;
  assign out_ch.data  = out_r.data;
  assign out_ch.last  = out_r.last;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_body_r |-> (body_left_r != '0))
    else $error("body open with zero bytes left");

  a_eos_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_ch.end_of_stream) |=> (!in_body_r && !newline_seen_r && !length_known_r))
    else $error("end of stream did not reset parser");

  a_len_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    !length_known_r |-> (message_length_r == '0))
    else $error("length held without known flag");

endmodule
